// ----- design/sdvl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdvl_pkg
// Shared types, codes and helpers for the self-describing variable-length
// field codec.
// ----------------------------------------------------------------------------
package sdvl_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned LEN_W   = 6;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned DEC_W   = 29;
   localparam int unsigned BITS_W  = 5;
   localparam int unsigned FLEN_W  = 3;

   // largest bit length that still fits the four-byte form
   localparam logic [LEN_W-1:0] MAX_LEN = 6'd29;

   // leading-byte prefixes
   localparam logic [1:0] PFX_TWO   = 2'b10;
   localparam logic [2:0] PFX_THREE = 3'b110;
   localparam logic [2:0] PFX_FOUR  = 3'b111;

   typedef enum logic [1:0] {
      ST_ENC_BYTE      = 2'd0,
      ST_DEC_FIELD     = 2'd1,
      ST_ENC_TOO_LARGE = 2'd2,
      ST_DEC_TRUNC     = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_last;
      logic [DEC_W-1:0]  dec_value;
      logic [BITS_W-1:0] dec_bits;
      logic [FLEN_W-1:0] dec_len;
      status_type        status;
   } rsp_type;

   // useful value bits of a field of the given byte length
   function automatic logic [BITS_W-1:0] cap_bits(input logic [FLEN_W-1:0] fb);
      logic [BITS_W-1:0] bits;
      case (fb)
         3'd1:    bits = 5'd7;
         3'd2:    bits = 5'd14;
         3'd3:    bits = 5'd21;
         3'd4:    bits = 5'd29;
         default: bits = 5'd0;
      endcase
      return bits;
   endfunction

endpackage

// ----- design/sdvl_enc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdvl_enc
// Encode datapath: picks the field size and forms the byte at the given
// position, or flags a value that does not fit.
// ----------------------------------------------------------------------------
module sdvl_enc (
   input  logic [sdvl_pkg::VALUE_W-1:0] enc_value,
   input  logic [sdvl_pkg::LEN_W-1:0]   bit_length,
   input  logic [1:0]                   idx,
   output sdvl_pkg::rsp_type            rsp
);

   logic                              err;
   logic [1:0]                        sz_m1;
   logic [1:0]                        rem;
   logic [sdvl_pkg::VALUE_W-1:0]      shifted;
   logic [sdvl_pkg::BYTE_W-1:0]       byte_val;

   always_comb begin
      if (bit_length == '0) begin
         err = |enc_value[31:29];
         if (enc_value[28:21] != '0) begin
            sz_m1 = 2'd3;
         end else if (enc_value[20:14] != '0) begin
            sz_m1 = 2'd2;
         end else if (enc_value[13:7] != '0) begin
            sz_m1 = 2'd1;
         end else begin
            sz_m1 = 2'd0;
         end
      end else begin
         err = bit_length > sdvl_pkg::MAX_LEN;
         if (bit_length <= 6'd7) begin
            sz_m1 = 2'd0;
         end else if (bit_length <= 6'd14) begin
            sz_m1 = 2'd1;
         end else if (bit_length <= 6'd21) begin
            sz_m1 = 2'd2;
         end else begin
            sz_m1 = 2'd3;
         end
      end
   end

   assign rem     = sz_m1 - idx;
   assign shifted = enc_value >> {rem, 3'b000};

   always_comb begin
      byte_val = shifted[7:0];
      if (idx == 2'd0) begin
         case (sz_m1)
            2'd0:    byte_val = {1'b0, shifted[6:0]};
            2'd1:    byte_val = {sdvl_pkg::PFX_TWO, shifted[5:0]};
            2'd2:    byte_val = {sdvl_pkg::PFX_THREE, shifted[4:0]};
            2'd3:    byte_val = {sdvl_pkg::PFX_FOUR, shifted[4:0]};
            default: byte_val = shifted[7:0];
         endcase
      end
   end

   always_comb begin
      rsp           = '0;
      rsp.out_last  = 1'b1;
      rsp.status    = sdvl_pkg::ST_ENC_TOO_LARGE;
      if (!err) begin
         rsp.out_byte = byte_val;
         rsp.out_last = (idx == sz_m1);
         rsp.status   = sdvl_pkg::ST_ENC_BYTE;
      end
   end

endmodule

// ----- design/sdvl_dec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdvl_dec
// Decode datapath: holds the field being gathered and reports a finished
// or truncated field.
// ----------------------------------------------------------------------------
module sdvl_dec (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [sdvl_pkg::BYTE_W-1:0] in_byte,
   input  logic                        in_last,
   output logic                        has_result,
   output sdvl_pkg::rsp_type           rsp
);

   logic [1:0]                   bytes_left_ff, bytes_left_in;
   logic [sdvl_pkg::FLEN_W-1:0]  field_bytes_ff, field_bytes_in;
   logic [sdvl_pkg::DEC_W-1:0]   acc_ff, acc_in;
   logic [sdvl_pkg::DEC_W-1:0]   acc_shift;

   assign acc_shift = {acc_ff[sdvl_pkg::DEC_W-9:0], in_byte};

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      field_bytes_in = field_bytes_ff;
      acc_in         = acc_ff;
      has_result     = 1'b0;
      rsp            = '0;
      rsp.out_last   = 1'b1;
      rsp.status     = sdvl_pkg::ST_DEC_FIELD;
      if (bytes_left_ff == 2'd0) begin
         if (!in_byte[7]) begin
            has_result    = 1'b1;
            rsp.dec_value = {22'd0, in_byte[6:0]};
            rsp.dec_bits  = sdvl_pkg::cap_bits(3'd1);
            rsp.dec_len   = 3'd1;
         end else begin
            if (in_byte[7:6] == sdvl_pkg::PFX_TWO) begin
               acc_in         = {23'd0, in_byte[5:0]};
               field_bytes_in = 3'd2;
               bytes_left_in  = 2'd1;
            end else if (in_byte[7:5] == sdvl_pkg::PFX_THREE) begin
               acc_in         = {24'd0, in_byte[4:0]};
               field_bytes_in = 3'd3;
               bytes_left_in  = 2'd2;
            end else begin
               acc_in         = {24'd0, in_byte[4:0]};
               field_bytes_in = 3'd4;
               bytes_left_in  = 2'd3;
            end
            if (in_last) begin
               has_result     = 1'b1;
               rsp.status     = sdvl_pkg::ST_DEC_TRUNC;
               bytes_left_in  = 2'd0;
               field_bytes_in = '0;
               acc_in         = '0;
            end
         end
      end else begin
         acc_in        = acc_shift;
         bytes_left_in = bytes_left_ff - 2'd1;
         if (bytes_left_in == 2'd0) begin
            has_result     = 1'b1;
            rsp.dec_value  = acc_shift;
            rsp.dec_bits   = sdvl_pkg::cap_bits(field_bytes_ff);
            rsp.dec_len    = field_bytes_ff;
            field_bytes_in = '0;
            acc_in         = '0;
         end else if (in_last) begin
            has_result     = 1'b1;
            rsp.status     = sdvl_pkg::ST_DEC_TRUNC;
            bytes_left_in  = 2'd0;
            field_bytes_in = '0;
            acc_in         = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= '0;
         field_bytes_ff <= '0;
         acc_ff         <= '0;
      end else if (take) begin
         bytes_left_ff  <= bytes_left_in;
         field_bytes_ff <= field_bytes_in;
         acc_ff         <= acc_in;
      end
   end

   a_idle_no_len: assert property (@(posedge clock) disable iff (reset)
      bytes_left_ff == 2'd0 |-> field_bytes_ff == '0)
      else $error("idle decoder holds a field length");

   a_left_below_len: assert property (@(posedge clock) disable iff (reset)
      bytes_left_ff != 2'd0 |-> {1'b0, bytes_left_ff} < field_bytes_ff)
      else $error("bytes left not below field length");

endmodule

// ----- design/sdvl_field_codec_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdvl_field_codec_core
// Self-describing variable-length field codec, encode and decode.
// ----------------------------------------------------------------------------
// usage
//   req_* carries one item per handshake (req_valid high, req_stall low).
//   req_mode 0 encodes req_enc_value into 1 to 4 bytes, one rsp item each;
//   req_mode 1 feeds one byte of an encoded stream, giving a decoded or
//   truncated field on its last byte and nothing for bytes in mid-field.
//   rsp_* carries results with the same valid/stall handshake; rsp_out_last
//   marks the final result of an item.
//   an item stays in the input register until its last result moves to the
//   output register, or until the decoder takes it when it makes none; its
//   results reach rsp_* through the output register. Decode items and
//   one-byte encodes run at one item per cycle while the output register is
//   free; a wider encode holds the input register until its last byte is out.
//   rsp_stall holds the output register and, through it, the input register,
//   so req_stall rises while a waiting item cannot move on.
//   reset clears both valid flags and returns the decoder to idle between fields.
// ----------------------------------------------------------------------------
module sdvl_field_codec_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic [sdvl_pkg::VALUE_W-1:0]   req_enc_value,
   input  logic [sdvl_pkg::LEN_W-1:0]     req_bit_length,
   input  logic [sdvl_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                           req_in_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [sdvl_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                           rsp_out_last,
   output logic [sdvl_pkg::DEC_W-1:0]     rsp_dec_value,
   output logic [sdvl_pkg::BITS_W-1:0]    rsp_dec_bits,
   output logic [sdvl_pkg::FLEN_W-1:0]    rsp_dec_len,
   output logic [1:0]                     rsp_status
);

   logic                          in_valid_ff;
   logic                          in_mode_ff;
   logic [sdvl_pkg::VALUE_W-1:0]  in_value_ff;
   logic [sdvl_pkg::LEN_W-1:0]    in_len_ff;
   logic [sdvl_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          in_last_ff;
   logic [1:0]                    idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sdvl_pkg::rsp_type             rsp_ff;

   sdvl_pkg::rsp_type             enc_rsp;
   sdvl_pkg::rsp_type             dec_rsp;
   logic                          dec_has;
   logic                          out_free;
   logic                          has_res;
   logic                          fire_out;
   logic                          consume;
   logic                          dec_take;

   sdvl_enc u_enc (
      .enc_value  (in_value_ff),
      .bit_length (in_len_ff),
      .idx        (idx_ff),
      .rsp        (enc_rsp)
   );

   sdvl_dec u_dec (
      .clock      (clock),
      .reset      (reset),
      .take       (dec_take),
      .in_byte    (in_byte_ff),
      .in_last    (in_last_ff),
      .has_result (dec_has),
      .rsp        (dec_rsp)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign has_res  = in_mode_ff ? dec_has : 1'b1;
   assign fire_out = in_valid_ff && out_free && has_res;
   assign consume  = in_valid_ff &&
                     (in_mode_ff ? (!dec_has || out_free) : (out_free && enc_rsp.out_last));
   assign dec_take = consume && in_mode_ff;
   assign req_stall = in_valid_ff && !consume;

   always_comb begin
      idx_in = idx_ff;
      if (in_valid_ff && !in_mode_ff && out_free) begin
         idx_in = enc_rsp.out_last ? 2'd0 : idx_ff + 2'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire_out) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff  <= req_mode;
         in_value_ff <= req_enc_value;
         in_len_ff   <= req_bit_length;
         in_byte_ff  <= req_in_byte;
         in_last_ff  <= req_in_last;
      end
      if (fire_out) begin
         rsp_ff <= in_mode_ff ? dec_rsp : enc_rsp;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_ff.out_byte;
   assign rsp_out_last  = rsp_ff.out_last;
   assign rsp_dec_value = rsp_ff.dec_value;
   assign rsp_dec_bits  = rsp_ff.dec_bits;
   assign rsp_dec_len   = rsp_ff.dec_len;
   assign rsp_status    = rsp_ff.status;

   a_idx_only_encode: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> in_valid_ff && !in_mode_ff)
      else $error("byte index set without an encode item");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && !consume)
      else $error("input stalled with nothing held");

   a_last_byte_ends: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_mode_ff && idx_ff == 2'd3 |-> enc_rsp.out_last)
      else $error("encode ran past its fourth byte");

endmodule

// ----- verif/sdvl_field_codec_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdvl_field_codec_core_tb
// Self-checking bench for the variable-length field codec. A queue of items
// feeds a clocked driver, and a clocked monitor checks every result against a
// cycle-free model of the encoder and of the decoder state. The run covers
// size boundaries, oversize values, whole, split and truncated fields, and
// encodes that fall inside a field. It then runs random items under
// randomized idling on both sides, a long output hold-off and full drains.
// ----------------------------------------------------------------------------
module sdvl_field_codec_core_tb;

   localparam int unsigned VALUE_W        = sdvl_pkg::VALUE_W;
   localparam int unsigned LEN_W          = sdvl_pkg::LEN_W;
   localparam int unsigned BYTE_W         = sdvl_pkg::BYTE_W;
   localparam int unsigned DEC_W          = sdvl_pkg::DEC_W;
   localparam int unsigned BITS_W         = sdvl_pkg::BITS_W;
   localparam int unsigned FLEN_W         = sdvl_pkg::FLEN_W;
   localparam logic        MODE_ENCODE    = 1'b0;
   localparam logic        MODE_DECODE    = 1'b1;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned LONG_HOLD      = 80;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned PHASE_ITEMS    = 155;

   typedef struct packed {
      logic              mode;
      logic [VALUE_W-1:0] enc_value;
      logic [LEN_W-1:0]  bit_length;
      logic [BYTE_W-1:0] in_byte;
      logic              in_last;
   } codec_item_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_mode = MODE_ENCODE;
   logic [VALUE_W-1:0]  req_enc_value = '0;
   logic [LEN_W-1:0]    req_bit_length = '0;
   logic [BYTE_W-1:0]   req_in_byte = '0;
   logic                req_in_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_out_last;
   logic [DEC_W-1:0]    rsp_dec_value;
   logic [BITS_W-1:0]   rsp_dec_bits;
   logic [FLEN_W-1:0]   rsp_dec_len;
   logic [1:0]          rsp_status;

   codec_item_type      pending_items[$];
   sdvl_pkg::rsp_type   owed_results[$];
   codec_item_type      offered;
   int unsigned         items_queued = 0;
   int unsigned         mismatches = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;
   int unsigned         hold_requests = 0;
   int unsigned         hold_served = 0;
   int unsigned         hold_left = 0;
   int unsigned         quiet_cycles = 0;
   logic                stall_next;
   sdvl_pkg::rsp_type   got;
   sdvl_pkg::rsp_type   want;

   // decoder state of the model
   logic [1:0]          dec_left = '0;
   logic [FLEN_W-1:0]   dec_total = '0;
   logic [DEC_W-1:0]    dec_acc = '0;

   sdvl_field_codec_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_enc_value  (req_enc_value),
      .req_bit_length (req_bit_length),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_dec_value  (rsp_dec_value),
      .rsp_dec_bits   (rsp_dec_bits),
      .rsp_dec_len    (rsp_dec_len),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic owe_result(input logic [BYTE_W-1:0] ob, input logic last,
                             input logic [DEC_W-1:0] dv,
                             input logic [BITS_W-1:0] db,
                             input logic [FLEN_W-1:0] dl,
                             input sdvl_pkg::status_type st);
      owed_results.push_back('{out_byte: ob, out_last: last, dec_value: dv,
                               dec_bits: db, dec_len: dl, status: st});
   endtask

   task automatic compute_codec_results(input codec_item_type it);
      int unsigned       nbytes;
      int                i;
      logic [BYTE_W-1:0] b;
      logic [BITS_W-1:0] bits;
      logic [VALUE_W-1:0] v;
      if (it.mode == MODE_ENCODE) begin
         v = it.enc_value;
         if (it.bit_length == '0) begin
            nbytes = (v <= 32'h7f) ? 1 : (v <= 32'h3fff) ? 2 :
                     (v <= 32'h1fffff) ? 3 : (v <= 32'h1fffffff) ? 4 : 5;
         end else begin
            nbytes = (it.bit_length <= 6'd7) ? 1 : (it.bit_length <= 6'd14) ? 2 :
                     (it.bit_length <= 6'd21) ? 3 :
                     (it.bit_length <= sdvl_pkg::MAX_LEN) ? 4 : 5;
         end
         if (nbytes > 4) begin
            owe_result('0, 1'b1, '0, '0, '0, sdvl_pkg::ST_ENC_TOO_LARGE);
            return;
         end
         for (i = nbytes - 1; i >= 0; i--) begin
            b = v[8*i +: 8];
            if (i == nbytes - 1) begin
               case (nbytes)
                  1: b = {1'b0, b[6:0]};
                  2: b = {sdvl_pkg::PFX_TWO, b[5:0]};
                  3: b = {sdvl_pkg::PFX_THREE, b[4:0]};
                  default: b = {sdvl_pkg::PFX_FOUR, b[4:0]};
               endcase
            end
            owe_result(b, i == 0, '0, '0, '0, sdvl_pkg::ST_ENC_BYTE);
         end
         return;
      end
      if (dec_left == '0) begin
         if (!it.in_byte[7]) begin
            owe_result('0, 1'b1, DEC_W'(it.in_byte[6:0]), 5'd7, 3'd1,
                       sdvl_pkg::ST_DEC_FIELD);
            return;
         end
         if (it.in_byte[7:6] == sdvl_pkg::PFX_TWO) begin
            dec_acc = DEC_W'(it.in_byte[5:0]);
            dec_total = 3'd2;
         end else if (it.in_byte[7:5] == sdvl_pkg::PFX_THREE) begin
            dec_acc = DEC_W'(it.in_byte[4:0]);
            dec_total = 3'd3;
         end else begin
            dec_acc = DEC_W'(it.in_byte[4:0]);
            dec_total = 3'd4;
         end
         dec_left = 2'(dec_total - 3'd1);
      end else begin
         dec_acc = {dec_acc[DEC_W-9:0], it.in_byte};
         dec_left = dec_left - 2'd1;
         if (dec_left == '0) begin
            case (dec_total)
               3'd2: bits = 5'd14;
               3'd3: bits = 5'd21;
               default: bits = 5'd29;
            endcase
            owe_result('0, 1'b1, dec_acc, bits, dec_total, sdvl_pkg::ST_DEC_FIELD);
            dec_total = '0;
            dec_acc = '0;
            return;
         end
      end
      if (it.in_last) begin
         owe_result('0, 1'b1, '0, '0, '0, sdvl_pkg::ST_DEC_TRUNC);
         dec_left = '0;
         dec_total = '0;
         dec_acc = '0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            compute_codec_results(offered);
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered = pending_items.pop_front();
               req_valid      <= 1'b1;
               req_mode       <= offered.mode;
               req_enc_value  <= offered.enc_value;
               req_bit_length <= offered.bit_length;
               req_in_byte    <= offered.in_byte;
               req_in_last    <= offered.in_last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{out_byte: rsp_out_byte, out_last: rsp_out_last,
                    dec_value: rsp_dec_value, dec_bits: rsp_dec_bits,
                    dec_len: rsp_dec_len,
                    status: sdvl_pkg::status_type'(rsp_status)};
            if (owed_results.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: byte=%02h status=%0d", rsp_out_byte, rsp_status);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
                   got.dec_value !== want.dec_value || got.dec_bits !== want.dec_bits ||
                   got.dec_len !== want.dec_len || rsp_status !== 2'(want.status)) begin
                  if (mismatches < 10) begin
                     $display({"mismatch: expected byte=%02h last=%0d value=%07h",
                               " bits=%0d len=%0d st=%0d"},
                              want.out_byte, want.out_last, want.dec_value, want.dec_bits,
                              want.dec_len, 2'(want.status));
                     $display({"          actual   byte=%02h last=%0d value=%07h",
                               " bits=%0d len=%0d st=%0d"},
                              rsp_out_byte, rsp_out_last, rsp_dec_value, rsp_dec_bits,
                              rsp_dec_len, rsp_status);
                  end
                  mismatches++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            stall_next = ($urandom_range(0, 99) < recv_idle_pct);
         end
         rsp_stall <= stall_next;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (pending_items.size() == 0 && !req_valid && owed_results.size() == 0)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("sdvl_field_codec_core_tb: FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic add_encode(input logic [VALUE_W-1:0] value, input logic [LEN_W-1:0] len);
      codec_item_type it;
      it.mode = MODE_ENCODE;
      it.enc_value = value;
      it.bit_length = len;
      it.in_byte = BYTE_W'($urandom);
      it.in_last = 1'($urandom_range(0, 1));
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic add_decode(input logic [BYTE_W-1:0] b, input logic last);
      codec_item_type it;
      it.mode = MODE_DECODE;
      it.enc_value = $urandom;
      it.bit_length = LEN_W'($urandom_range(0, 32));
      it.in_byte = b;
      it.in_last = last;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic add_random_encode();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 5)
         add_encode($urandom >> $urandom_range(0, 31), '0);
      else if (sel < 9)
         add_encode($urandom, LEN_W'($urandom_range(1, 29)));
      else
         add_encode($urandom, LEN_W'($urandom_range(30, 32)));
   endtask

   // well-formed field, sometimes cut short by in_last
   task automatic add_random_field();
      int unsigned       nbytes;
      int unsigned       cut;
      int unsigned       i;
      logic [BYTE_W-1:0] b;
      logic              last;
      nbytes = $urandom_range(1, 4);
      cut = nbytes;
      if (nbytes > 1 && $urandom_range(0, 9) == 0)
         cut = $urandom_range(1, nbytes - 1);
      for (i = 0; i < cut; i++) begin
         b = BYTE_W'($urandom);
         if (i == 0) begin
            case (nbytes)
               1: b[7] = 1'b0;
               2: b[7:6] = sdvl_pkg::PFX_TWO;
               3: b[7:5] = sdvl_pkg::PFX_THREE;
               default: b[7:5] = sdvl_pkg::PFX_FOUR;
            endcase
         end
         if (i != cut - 1)
            last = 1'b0;
         else if (cut < nbytes)
            last = 1'b1;
         else
            last = ($urandom_range(0, 3) == 0);
         add_decode(b, last);
         if (i + 1 < cut && $urandom_range(0, 19) == 0)
            add_random_encode();
      end
   endtask

   task automatic add_random_items(input int unsigned count);
      int unsigned target;
      int unsigned pick;
      target = items_queued + count;
      while (items_queued < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            add_random_encode();
         else if (pick < 90)
            add_random_field();
         else
            add_decode(BYTE_W'($urandom), $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || owed_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 29;
      recv_idle_pct = 46;

      // size boundaries, length override and oversize
      add_encode(32'h0000_0000, 6'd0);
      add_encode(32'h0000_007f, 6'd0);
      add_encode(32'h0000_0080, 6'd0);
      add_encode(32'h0000_4000, 6'd0);
      add_encode(32'h001f_ffff, 6'd0);
      add_encode(32'h1fff_ffff, 6'd0);
      add_encode(32'h2000_0000, 6'd0);
      add_encode(32'hffff_ffff, 6'd1);
      add_encode(32'hffff_ffff, 6'd8);
      add_encode(32'hffff_ffff, 6'd22);
      add_encode(32'hffff_ffff, 6'd29);
      add_encode(32'h0000_0000, 6'd30);
      add_encode(32'h0000_0001, 6'd32);

      // whole fields, an encode inside one, truncation
      add_decode(8'h7f, 1'b1);
      add_decode(8'hbf, 1'b0);
      add_decode(8'hff, 1'b0);
      add_decode(8'hff, 1'b0);
      add_encode(32'h0000_3fff, 6'd0);
      add_decode(8'hff, 1'b0);
      add_decode(8'hff, 1'b0);
      add_decode(8'hff, 1'b1);
      add_decode(8'h80, 1'b1);
      add_decode(8'hc5, 1'b0);
      wait_drained();
      add_decode(8'h00, 1'b1);
      wait_drained();
      add_random_items(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 46;
      recv_idle_pct = 29;
      add_random_items(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      add_random_items(PHASE_ITEMS);
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && owed_results.size() == 0)
         $display("sdvl_field_codec_core_tb: PASS");
      else
         $display("sdvl_field_codec_core_tb: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
design/sdvl_pkg.sv
design/sdvl_enc.sv
design/sdvl_dec.sv
design/sdvl_field_codec_core.sv
verif/sdvl_field_codec_core_tb.sv
